FILE: rtl/gdpg_pkg.sv
// gdpg_pkg: constants, types and tables for the gaussian density pixel generator
// no dependencies; compiled before the interfaces and the modules
`timescale 1ns / 1ps

package gdpg_pkg;

  // configuration port
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 32;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_MEAN_ROW  = 2'd0,
    REG_MEAN_COL  = 2'd1,
    REG_INV_SIGMA = 2'd2,
    REG_PEAK      = 2'd3
  } cfg_reg_t;

  localparam int MEAN_BITS    = 16;
  localparam int SCALE_BITS   = 32;
  localparam int DENSITY_BITS = 32;

  localparam logic [MEAN_BITS-1:0]  RST_MEAN_ROW  = 16'd792;
  localparam logic [MEAN_BITS-1:0]  RST_MEAN_COL  = 16'd792;
  localparam logic [SCALE_BITS-1:0] RST_INV_SIGMA = 32'd8388608;
  localparam logic [SCALE_BITS-1:0] RST_PEAK      = 32'd2670177;

  // exp(-x) evaluation, x in Q.32 below 32.0
  localparam int XQ_BITS   = 37;
  localparam int N_BITS    = 6;
  localparam int Q32_BITS  = 32;
  localparam int T_BITS    = 33;
  localparam logic [Q32_BITS-1:0] LN2_Q32 = 32'd2977044472;
  localparam logic [T_BITS-1:0]   ONE_Q32 = 33'h1_0000_0000;

  // horner series, divide by k through floor(2^36 / k)
  localparam int EXP_TERMS   = 12;
  localparam int RECIP_SHIFT = 36;
  localparam int RECIP_BITS  = 37;
  localparam int K_BITS      = 4;
  localparam logic [RECIP_BITS-1:0] RECIP_Q36 [EXP_TERMS] = '{
    37'd68719476736,  // k = 1
    37'd34359738368,
    37'd22906492245,
    37'd17179869184,
    37'd13743895347,
    37'd11453246122,
    37'd9817068105,
    37'd8589934592,
    37'd7635497415,
    37'd6871947673,
    37'd6247225157,
    37'd5726623061    // k = 12
  };

  // pipeline stage map
  localparam int ST_DIV0    = 5;
  localparam int ST_HORNER0 = ST_DIV0 + N_BITS;
  localparam int ST_SHIFT   = ST_HORNER0 + 3 * EXP_TERMS;
  localparam int ST_MULT    = ST_SHIFT + 1;
  localparam int ST_OUT     = ST_MULT + 1;
  localparam int PIPE_DEPTH = ST_OUT + 1;

  // values that ride along the series stages
  typedef struct packed {
    logic                zero;
    logic [N_BITS-1:0]   n;
    logic [Q32_BITS-1:0] r;
  } side_t;

endpackage

FILE: rtl/gdpg_pix_if.sv
// gdpg_pix_if: pixel coordinate channel, valid/ready with row and column
// depends on nothing
`timescale 1ns / 1ps

interface gdpg_pix_if #(
  parameter int COORD_BITS = 12
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] row_index;
  logic [COORD_BITS-1:0] col_index;

  modport source (output valid, output row_index, output col_index, input ready);
  modport sink   (input valid, input row_index, input col_index, output ready);
endinterface

FILE: rtl/gdpg_den_if.sv
// gdpg_den_if: density result channel, valid/ready with Q8.24 density
// depends on gdpg_pkg
`timescale 1ns / 1ps

interface gdpg_den_if;
  logic                              valid;
  logic                              ready;
  logic [gdpg_pkg::DENSITY_BITS-1:0] density;

  modport source (output valid, output density, input ready);
  modport sink   (input valid, input density, output ready);
endinterface

FILE: rtl/gaussian_density_pixel_generator.sv
// gaussian_density_pixel_generator: pipelined 2-D gaussian density per pixel
// depends on gdpg_pkg, gdpg_pix_if, gdpg_den_if
// throughput: one pixel per cycle when the output is not stalled; the 12-step
//   horner series for exp(-r) sets the depth, three stages per step (product,
//   reciprocal multiply, correction)
// stalls hold each stage in place; an empty stage keeps taking data
// reset (rst_n low, synchronous) empties the pipeline and loads register defaults
`timescale 1ns / 1ps

module gaussian_density_pixel_generator #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 24
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [gdpg_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [gdpg_pkg::CFG_DATA_BITS-1:0] cfg_data,
  gdpg_pix_if.sink                           in_pix,
  gdpg_den_if.source                         out_den
);

  localparam int CW    = COORD_BITS;
  localparam int DW    = (CW + 4 > gdpg_pkg::MEAN_BITS) ? CW + 4 : gdpg_pkg::MEAN_BITS;
  localparam int SQW   = 2 * DW;
  localparam int D2W   = SQW + 1;
  localparam int PPW   = D2W + 16;
  localparam int PW    = D2W + 32;
  localparam int XQW   = gdpg_pkg::XQ_BITS;
  localparam int SHIFT = 32 - FRAC_BITS;
  localparam int NST   = gdpg_pkg::PIPE_DEPTH;
  localparam int NB    = gdpg_pkg::N_BITS;
  localparam int NT    = gdpg_pkg::EXP_TERMS;
  localparam int TW    = gdpg_pkg::T_BITS;
  localparam int QW    = gdpg_pkg::Q32_BITS;
  localparam int RW    = gdpg_pkg::RECIP_BITS;
  localparam logic [PW-1:0] P_LIMIT = PW'(32) << (FRAC_BITS + 8);

  // configuration registers
  logic [gdpg_pkg::MEAN_BITS-1:0]  mean_row_r, mean_col_r;
  logic [gdpg_pkg::SCALE_BITS-1:0] inv_r, peak_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mean_row_r <= gdpg_pkg::RST_MEAN_ROW;
      mean_col_r <= gdpg_pkg::RST_MEAN_COL;
      inv_r      <= gdpg_pkg::RST_INV_SIGMA;
      peak_r     <= gdpg_pkg::RST_PEAK;
    end else if (cfg_we) begin
      unique case (gdpg_pkg::cfg_reg_t'(cfg_index))
        gdpg_pkg::REG_MEAN_ROW:  mean_row_r <= cfg_data[gdpg_pkg::MEAN_BITS-1:0];
        gdpg_pkg::REG_MEAN_COL:  mean_col_r <= cfg_data[gdpg_pkg::MEAN_BITS-1:0];
        gdpg_pkg::REG_INV_SIGMA: inv_r      <= cfg_data[gdpg_pkg::SCALE_BITS-1:0];
        gdpg_pkg::REG_PEAK:      peak_r     <= cfg_data[gdpg_pkg::SCALE_BITS-1:0];
      endcase
    end
  end

  // pipeline flow: a stage moves with the sink ready or a stage at or after it empty
  logic [NST-1:0] v_r;
  logic [NST-1:0] adv;

  for (genvar i = 0; i < NST; i++) begin : g_adv
    assign adv[i] = out_den.ready || !(&v_r[NST-1:i]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (adv[0]) v_r[0] <= in_pix.valid;
      for (int i = 1; i < NST; i++) begin
        if (adv[i]) v_r[i] <= v_r[i-1];
      end
    end
  end

  assign in_pix.ready = adv[0];

  // stage 0: distance from the mean on each axis, Q.4
  logic [DW-1:0] c_row, c_col, m_row, m_col;
  logic [DW-1:0] dr_nxt, dc_nxt, dr_r, dc_r;

  always_comb begin
    c_row  = DW'({in_pix.row_index, 4'b0000});
    c_col  = DW'({in_pix.col_index, 4'b0000});
    m_row  = DW'(mean_row_r);
    m_col  = DW'(mean_col_r);
    dr_nxt = (c_row >= m_row) ? c_row - m_row : m_row - c_row;
    dc_nxt = (c_col >= m_col) ? c_col - m_col : m_col - c_col;
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      dr_r <= dr_nxt;
      dc_r <= dc_nxt;
    end
  end

  // stage 1: squares
  logic [SQW-1:0] sqr_nxt, sqc_nxt, sqr_r, sqc_r;
  assign sqr_nxt = SQW'(dr_r) * SQW'(dr_r);
  assign sqc_nxt = SQW'(dc_r) * SQW'(dc_r);

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      sqr_r <= sqr_nxt;
      sqc_r <= sqc_nxt;
    end
  end

  // stage 2: squared distance, Q.8
  logic [D2W-1:0] d2_nxt, d2_r;
  assign d2_nxt = D2W'(sqr_r) + D2W'(sqc_r);

  always_ff @(posedge clk) begin
    if (adv[2]) d2_r <= d2_nxt;
  end

  // stage 3: partial products with the two halves of 1/(2 sigma^2)
  logic [PPW-1:0] plo_nxt, phi_nxt, plo_r, phi_r;
  assign plo_nxt = PPW'(d2_r) * PPW'(inv_r[15:0]);
  assign phi_nxt = PPW'(d2_r) * PPW'(inv_r[31:16]);

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      plo_r <= plo_nxt;
      phi_r <= phi_nxt;
    end
  end

  // stage 4: argument in Q.32 and underflow flag
  logic [PW-1:0]  p_sum;
  logic [XQW-1:0] xq_nxt, xq_r;
  logic           zero_nxt, zero_r;

  always_comb begin
    p_sum    = (PW'(phi_r) << 16) + PW'(plo_r);
    zero_nxt = (p_sum >= P_LIMIT);
    xq_nxt   = XQW'(XQW'(p_sum >> 8) << SHIFT);
  end

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      xq_r   <= xq_nxt;
      zero_r <= zero_nxt;
    end
  end

  // restoring division by ln 2, one quotient bit per stage
  logic [XQW-1:0] dv_rem_r  [NB];
  logic [NB-1:0]  dv_n_r    [NB];
  logic           dv_zero_r [NB];

  for (genvar j = 0; j < NB; j++) begin : g_div
    localparam int B = NB - 1 - j;
    localparam logic [XQW-1:0] SUB = XQW'(gdpg_pkg::LN2_Q32) << B;
    logic [XQW-1:0] rem_in, rem_nxt;
    logic [NB-1:0]  n_in, n_nxt;
    logic           zero_in, ge;

    if (j == 0) begin : g_first
      assign rem_in  = xq_r;
      assign n_in    = '0;
      assign zero_in = zero_r;
    end else begin : g_rest
      assign rem_in  = dv_rem_r[j-1];
      assign n_in    = dv_n_r[j-1];
      assign zero_in = dv_zero_r[j-1];
    end

    always_comb begin
      ge       = (rem_in >= SUB);
      rem_nxt  = ge ? rem_in - SUB : rem_in;
      n_nxt    = n_in;
      n_nxt[B] = ge;
    end

    always_ff @(posedge clk) begin
      if (adv[gdpg_pkg::ST_DIV0 + j]) begin
        dv_rem_r[j]  <= rem_nxt;
        dv_n_r[j]    <= n_nxt;
        dv_zero_r[j] <= zero_in;
      end
    end
  end

  gdpg_pkg::side_t div_side;
  assign div_side = '{zero: dv_zero_r[NB-1], n: dv_n_r[NB-1], r: dv_rem_r[NB-1][QW-1:0]};

  // horner series for exp(-r): t = 1 - (r * t) / k, k from 12 down to 1
  logic [QW-1:0]         ha_p_r    [NT];
  gdpg_pkg::side_t       ha_side_r [NT];
  logic [QW-1:0]         hb_p_r    [NT];
  logic [QW-1:0]         hb_qe_r   [NT];
  gdpg_pkg::side_t       hb_side_r [NT];
  logic [TW-1:0]         hc_t_r    [NT];
  gdpg_pkg::side_t       hc_side_r [NT];

  for (genvar s = 0; s < NT; s++) begin : g_horner
    localparam int ST_A = gdpg_pkg::ST_HORNER0 + 3 * s;
    localparam logic [gdpg_pkg::K_BITS-1:0] KV = gdpg_pkg::K_BITS'(NT - s);
    localparam logic [RW-1:0] M = gdpg_pkg::RECIP_Q36[NT - s - 1];

    logic [TW-1:0]      t_in;
    gdpg_pkg::side_t    side_in;
    logic [QW+TW-1:0]   prod_a;
    logic [QW+RW-1:0]   prod_b;
    logic [QW+3:0]      kq, rem;
    logic [QW-1:0]      q;
    logic [TW-1:0]      t_nxt;

    if (s == 0) begin : g_first
      assign t_in    = gdpg_pkg::ONE_Q32;
      assign side_in = div_side;
    end else begin : g_rest
      assign t_in    = hc_t_r[s-1];
      assign side_in = hc_side_r[s-1];
    end

    always_comb begin
      prod_a = (QW+TW)'(side_in.r) * (QW+TW)'(t_in);
      prod_b = (QW+RW)'(ha_p_r[s]) * (QW+RW)'(M);
      kq     = (QW+4)'(hb_qe_r[s]) * (QW+4)'(KV);
      rem    = (QW+4)'(hb_p_r[s]) - kq;
      q      = hb_qe_r[s] + QW'(rem >= (QW+4)'(KV));
      t_nxt  = gdpg_pkg::ONE_Q32 - TW'(q);
    end

    always_ff @(posedge clk) begin
      if (adv[ST_A]) begin
        ha_p_r[s]    <= prod_a[2*QW-1:QW];
        ha_side_r[s] <= side_in;
      end
      if (adv[ST_A + 1]) begin
        hb_p_r[s]    <= ha_p_r[s];
        hb_qe_r[s]   <= prod_b[gdpg_pkg::RECIP_SHIFT +: QW];
        hb_side_r[s] <= ha_side_r[s];
      end
      if (adv[ST_A + 2]) begin
        hc_t_r[s]    <= t_nxt;
        hc_side_r[s] <= hb_side_r[s];
      end
    end
  end

  // scale by 2^-n
  logic [TW-1:0] e_nxt, e_r;
  logic          e_zero_r;
  assign e_nxt = hc_t_r[NT-1] >> hc_side_r[NT-1].n;

  always_ff @(posedge clk) begin
    if (adv[gdpg_pkg::ST_SHIFT]) begin
      e_r      <= e_nxt;
      e_zero_r <= hc_side_r[NT-1].zero;
    end
  end

  // multiply by the peak value
  logic [TW+QW-1:0] pk_prod;
  logic [TW-1:0]    pk_nxt, pk_r;
  logic             pk_zero_r;

  always_comb begin
    pk_prod = (TW+QW)'(e_r) * (TW+QW)'(peak_r);
    pk_nxt  = pk_prod[TW+QW-1:QW];
  end

  always_ff @(posedge clk) begin
    if (adv[gdpg_pkg::ST_MULT]) begin
      pk_r      <= pk_nxt;
      pk_zero_r <= e_zero_r;
    end
  end

  // output register: underflow to zero, clamp at the maximum
  logic [gdpg_pkg::DENSITY_BITS-1:0] density_nxt, density_r;

  always_comb begin
    if (pk_zero_r) begin
      density_nxt = '0;
    end else if (pk_r[TW-1]) begin
      density_nxt = '1;
    end else begin
      density_nxt = pk_r[gdpg_pkg::DENSITY_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[gdpg_pkg::ST_OUT]) density_r <= density_nxt;
  end

  assign out_den.valid   = v_r[NST-1];
  assign out_den.density = density_r;

endmodule

FILE: rtl/gdpg_checker.sv
// gdpg_checker: port-level assertions for the gaussian density pixel generator
// depends on gdpg_pkg; bound to gaussian_density_pixel_generator below
`timescale 1ns / 1ps

module gdpg_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [gdpg_pkg::DENSITY_BITS-1:0] density
);

  localparam int RUN_BITS = $clog2(gdpg_pkg::PIPE_DEPTH + 1);
  localparam logic [RUN_BITS-1:0] RUN_LEN = RUN_BITS'(gdpg_pkg::PIPE_DEPTH);

  // consecutive cycles out of reset with the sink ready
  logic [RUN_BITS-1:0] run_r;

  always_ff @(posedge clk) begin
    if (!rst_n || !out_ready) begin
      run_r <= '0;
    end else if (run_r != RUN_LEN) begin
      run_r <= run_r + RUN_BITS'(1);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(density))
    else $error("density changed while stalled");

  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with an empty output");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $past(in_valid && in_ready, gdpg_pkg::PIPE_DEPTH) && (run_r >= RUN_LEN) |-> out_valid)
    else $error("transaction did not arrive after the pipeline depth");

endmodule

bind gaussian_density_pixel_generator gdpg_checker u_gdpg_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_pix.valid),
  .in_ready  (in_pix.ready),
  .out_valid (out_den.valid),
  .out_ready (out_den.ready),
  .density   (out_den.density)
);
